// ===== hdl/mscl_pkg.sv =====
// Shared types, signature tables and a helper function for the magic signature classifier.
package mscl_pkg;

    localparam int unsigned POS_W    = 10;
    localparam int unsigned FLAG_N   = 12;
    localparam logic [POS_W-1:0] POS_MAX = 10'd1023;

    // Flag positions in the signature flag vector.
    localparam int unsigned F_7Z   = 0;
    localparam int unsigned F_RAR5 = 1;
    localparam int unsigned F_RAR4 = 2;
    localparam int unsigned F_XAR  = 3;
    localparam int unsigned F_DMG  = 4;
    localparam int unsigned F_PDF  = 5;
    localparam int unsigned F_RPM  = 6;
    localparam int unsigned F_SWFC = 7;
    localparam int unsigned F_SWFF = 8;
    localparam int unsigned F_RTF  = 9;
    localparam int unsigned F_MSI  = 10;
    localparam int unsigned F_EPUB = 11;

    localparam logic [7:0] NEWLINE = 8'h0A;

    localparam logic [7:0] SIG_7Z   [6] = '{8'h37, 8'h7A, 8'hBC, 8'hAF, 8'h27, 8'h1C};
    localparam logic [7:0] SIG_RAR5 [8] = '{8'h52, 8'h61, 8'h72, 8'h21,
                                            8'h1A, 8'h07, 8'h01, 8'h00};
    localparam logic [7:0] SIG_RAR4 [7] = '{8'h52, 8'h61, 8'h72, 8'h21,
                                            8'h1A, 8'h07, 8'h00};
    localparam logic [7:0] SIG_XAR  [4] = '{8'h78, 8'h61, 8'h72, 8'h21};
    localparam logic [7:0] SIG_DMG  [4] = '{8'h6B, 8'h6F, 8'h6C, 8'h79};
    localparam logic [7:0] SIG_PDF  [5] = '{8'h25, 8'h50, 8'h44, 8'h46, 8'h2D};
    localparam logic [7:0] SIG_RPM  [4] = '{8'hED, 8'hAB, 8'hEE, 8'hDB};
    localparam logic [7:0] SIG_SWFC [3] = '{8'h43, 8'h57, 8'h53};
    localparam logic [7:0] SIG_SWFF [3] = '{8'h46, 8'h57, 8'h53};
    localparam logic [7:0] SIG_RTF  [5] = '{8'h7B, 8'h5C, 8'h72, 8'h74, 8'h66};
    localparam logic [7:0] SIG_MSI  [9] = '{8'h53, 8'h5A, 8'h44, 8'h44, 8'h88,
                                            8'hF0, 8'h27, 8'h33, 8'h41};
    localparam logic [7:0] SIG_EPUB_HEAD [4] = '{8'h50, 8'h4B, 8'h03, 8'h04};
    localparam logic [7:0] SIG_EPUB_TAIL [28] = '{
        8'h6D, 8'h69, 8'h6D, 8'h65, 8'h74, 8'h79, 8'h70, 8'h65,
        8'h61, 8'h70, 8'h70, 8'h6C, 8'h69, 8'h63, 8'h61, 8'h74,
        8'h69, 8'h6F, 8'h6E, 8'h2F, 8'h65, 8'h70, 8'h75, 8'h62,
        8'h2B, 8'h7A, 8'h69, 8'h70};
    localparam logic [POS_W-1:0] EPUB_TAIL_START = 10'd30;
    localparam logic [POS_W-1:0] EPUB_TAIL_END   = 10'd58;

    typedef enum logic [3:0] {
        FT_NONE = 4'd0,
        FT_7Z   = 4'd1,
        FT_RAR  = 4'd2,
        FT_XAR  = 4'd3,
        FT_DMG  = 4'd4,
        FT_PDF  = 4'd5,
        FT_RPM  = 4'd6,
        FT_SWF  = 4'd7,
        FT_RTF  = 4'd8,
        FT_MSI  = 4'd9,
        FT_EPUB = 4'd10
    } t_file_type;

    // Per-file tracking state.
    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [FLAG_N-1:0] flags;
        logic              nl_seen;
        logic [7:0]        sz_major;
        logic [7:0]        sz_minor;
        logic [15:0]       xar_size;
        logic [15:0]       xar_ver;
        logic [31:0]       dmg_ver;
        logic [31:0]       dmg_size;
    } t_track;

    typedef struct packed {
        t_file_type  file_type;
        logic [31:0] version_major;
        logic [7:0]  version_minor;
    } t_result;

    localparam t_track TRACK_RESET = '{
        pos: '0, flags: '1, nl_seen: 1'b0, sz_major: '0, sz_minor: '0,
        xar_size: '0, xar_ver: '0, dmg_ver: '0, dmg_size: '0};

    // Returns a mask of the signature flags that the byte at position p rules out.
    function automatic logic [FLAG_N-1:0] f_clear_mask(input logic [POS_W-1:0] p,
                                                       input logic [7:0] b);
        logic [FLAG_N-1:0] m;
        logic [POS_W-1:0]  off;
        m   = '0;
        off = p - EPUB_TAIL_START;
        if (p < 10'd6 && SIG_7Z[p[2:0]]   != b) m[F_7Z]   = 1'b1;
        if (p < 10'd8 && SIG_RAR5[p[2:0]] != b) m[F_RAR5] = 1'b1;
        if (p < 10'd7 && SIG_RAR4[p[2:0]] != b) m[F_RAR4] = 1'b1;
        if (p < 10'd4 && SIG_XAR[p[1:0]]  != b) m[F_XAR]  = 1'b1;
        if (p < 10'd4 && SIG_DMG[p[1:0]]  != b) m[F_DMG]  = 1'b1;
        if (p < 10'd5 && SIG_PDF[p[2:0]]  != b) m[F_PDF]  = 1'b1;
        if (p < 10'd4 && SIG_RPM[p[1:0]]  != b) m[F_RPM]  = 1'b1;
        if (p < 10'd3 && SIG_SWFC[p[1:0]] != b) m[F_SWFC] = 1'b1;
        if (p < 10'd3 && SIG_SWFF[p[1:0]] != b) m[F_SWFF] = 1'b1;
        if (p < 10'd5 && SIG_RTF[p[2:0]]  != b) m[F_RTF]  = 1'b1;
        if (p < 10'd9 && SIG_MSI[p[3:0]]  != b) m[F_MSI]  = 1'b1;
        if (p < 10'd4 && SIG_EPUB_HEAD[p[1:0]] != b) m[F_EPUB] = 1'b1;
        if (p >= EPUB_TAIL_START && p < EPUB_TAIL_END && SIG_EPUB_TAIL[off[4:0]] != b)
            m[F_EPUB] = 1'b1;
        return m;
    endfunction

endpackage

// ===== hdl/mscl_tracker.sv =====
// Per-file state registers and the byte-by-byte update of flags and header fields.
module mscl_tracker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [7:0]                  i_byte,
    input  logic                        i_last,
    output mscl_pkg::t_track            o_next
);
    import mscl_pkg::*;

    t_track r_state;
    t_track n_state;

    // Updated state including the byte now presented.
    always_comb begin
        logic [POS_W-1:0] p;
        p       = r_state.pos;
        n_state = r_state;
        n_state.flags = r_state.flags & ~f_clear_mask(p, i_byte);
        if (i_byte == NEWLINE) n_state.nl_seen = 1'b1;
        if (p == 10'd6) n_state.sz_major = i_byte;
        if (p == 10'd7) n_state.sz_minor = i_byte;
        if (p == 10'd4 || p == 10'd5) n_state.xar_size = {r_state.xar_size[7:0], i_byte};
        if (p == 10'd6 || p == 10'd7) n_state.xar_ver  = {r_state.xar_ver[7:0], i_byte};
        if (p >= 10'd4 && p < 10'd8)  n_state.dmg_ver  = {r_state.dmg_ver[23:0], i_byte};
        if (p >= 10'd8 && p < 10'd12) n_state.dmg_size = {r_state.dmg_size[23:0], i_byte};
        if (p != POS_MAX) n_state.pos = p + 10'd1;
    end

    assign o_next = n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TRACK_RESET;
        end else if (i_step) begin
            // The last byte of a file closes it; the next byte starts a new one.
            r_state <= i_last ? TRACK_RESET : n_state;
        end
    end

endmodule

// ===== hdl/mscl_classify.sv =====
// Priority decision that names the first matching file type from the updated state.
module mscl_classify (
    input  mscl_pkg::t_track  i_track,
    output mscl_pkg::t_result o_result
);
    import mscl_pkg::*;

    // pos is the byte count, saturated at a value above every length bound.
    always_comb begin
        logic [POS_W-1:0] len;
        len = i_track.pos;
        o_result = '{file_type: FT_NONE, version_major: '0, version_minor: '0};
        priority if (i_track.flags[F_7Z] && len >= 10'd8) begin
            o_result.file_type     = FT_7Z;
            o_result.version_major = {24'd0, i_track.sz_major};
            o_result.version_minor = i_track.sz_minor;
        end else if (i_track.flags[F_RAR5] && len >= 10'd8) begin
            o_result.file_type     = FT_RAR;
            o_result.version_major = 32'd5;
        end else if (i_track.flags[F_RAR4] && len >= 10'd7) begin
            o_result.file_type     = FT_RAR;
            o_result.version_major = 32'd4;
        end else if (i_track.flags[F_XAR] && len >= 10'd28 && i_track.xar_size >= 16'd28) begin
            o_result.file_type     = FT_XAR;
            o_result.version_major = {16'd0, i_track.xar_ver};
        end else if (i_track.flags[F_DMG] && len >= 10'd512
                     && i_track.dmg_size == 32'd512) begin
            o_result.file_type     = FT_DMG;
            o_result.version_major = i_track.dmg_ver;
        end else if (i_track.flags[F_PDF] && len >= 10'd8 && i_track.nl_seen) begin
            o_result.file_type = FT_PDF;
        end else if (i_track.flags[F_RPM] && len >= 10'd4) begin
            o_result.file_type = FT_RPM;
        end else if ((i_track.flags[F_SWFC] || i_track.flags[F_SWFF]) && len >= 10'd3) begin
            o_result.file_type = FT_SWF;
        end else if (i_track.flags[F_RTF] && len >= 10'd5) begin
            o_result.file_type = FT_RTF;
        end else if (i_track.flags[F_MSI] && len >= 10'd9) begin
            o_result.file_type = FT_MSI;
        end else if (i_track.flags[F_EPUB] && len >= 10'd58) begin
            o_result.file_type = FT_EPUB;
        end else begin
            o_result.file_type = FT_NONE;
        end
    end

endmodule

// ===== hdl/magic_signature_file_classifier_core.sv =====
// Top level of the magic signature file classifier: input stage, tracker, classifier, output register.
// A last byte's word is held in the input stage, then its result is registered and shown on m_tvalid.
// Throughput: one byte word per cycle; the input stage and the result register are separate,
// so bytes keep flowing while a finished result waits on m_tready.
// Only a stalled result blocks a following last byte; other bytes pass the stalled result.
// Reset (i_rst_n low, synchronous) empties both stages and returns the file state to offset zero.
module magic_signature_file_classifier_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave side: one file byte per word.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tlast,   // last_byte
    // Master side: one result word per file.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [3:0] file_type, [35:4] version_major,
                                   // [43:36] version_minor, [47:44] zero
);
    import mscl_pkg::*;

    // Input stage holds one byte word.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Result register.
    logic       r_out_valid;
    t_result    r_out_result;

    logic       w_adv;
    logic       w_load;
    t_track     w_next;
    t_result    w_result;

    // A byte leaves the input stage when it is not a last byte, or when the
    // result register is free or being emptied in this cycle.
    assign w_adv    = r_in_valid && (!r_in_last || !r_out_valid || m_tready);
    assign w_load   = w_adv && r_in_last;
    assign s_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_byte <= s_tdata;
            r_in_last <= s_tlast;
        end
    end

    mscl_tracker u_tracker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_next  (w_next)
    );

    mscl_classify u_classify (
        .i_track  (w_next),
        .o_result (w_result)
    );

    // The result register fills on a last byte and drains when the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_result <= w_result;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {4'd0, r_out_result.version_minor, r_out_result.version_major,
                       r_out_result.file_type};

endmodule

// ===== hdl/mscl_checker.sv =====
// Port-level checks of the classifier's result words, bound to the top level.
module mscl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);
    import mscl_pkg::*;

    // A stalled result word holds steady.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Reset empties the result register.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // Only 7z, rar, xar and dmg carry a major version.
    a_major: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[3:0] != FT_7Z && m_tdata[3:0] != FT_RAR
        && m_tdata[3:0] != FT_XAR && m_tdata[3:0] != FT_DMG |-> m_tdata[35:4] == 32'd0)
        else $error("major version on a type without one");

    // Only 7z carries a minor version; rar major is four or five.
    a_minor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[3:0] != FT_7Z |-> m_tdata[43:36] == 8'd0)
        else $error("minor version on a type without one");

    a_rar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[3:0] == FT_RAR |-> m_tdata[35:4] == 32'd4 || m_tdata[35:4] == 32'd5)
        else $error("rar version out of range");

endmodule

bind magic_signature_file_classifier_core mscl_checker u_mscl_checker (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for the magic signature file classifier core.
`timescale 1ns / 1ps

module testbench;
    import mscl_pkg::*;

    // Run control.
    localparam int CLK_HALF    = 10;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_LEN   = 80;
    localparam int ITEM_TARGET = 1800;
    localparam int RAND_FILES  = 12;
    localparam int BUF_LEN     = 1300;
    localparam int PRINT_CAP   = 40;

    // Signature indexes, one per match flag.
    localparam int MG_7Z    = 0;
    localparam int MG_RAR5  = 1;
    localparam int MG_RAR4  = 2;
    localparam int MG_XAR   = 3;
    localparam int MG_DMG   = 4;
    localparam int MG_PDF   = 5;
    localparam int MG_RPM   = 6;
    localparam int MG_SWFC  = 7;
    localparam int MG_SWFF  = 8;
    localparam int MG_RTF   = 9;
    localparam int MG_MSI   = 10;
    localparam int MG_EPUB  = 11;
    localparam int MG_COUNT = 12;
    // Random file kind that carries no signature at all.
    localparam int MG_NOISE = 12;

    // Leading signatures, first file byte in the top bits.
    localparam logic [47:0]  MAGIC_7Z   = 48'h377ABCAF271C;
    localparam logic [63:0]  MAGIC_RAR5 = 64'h526172211A070100;
    localparam logic [55:0]  MAGIC_RAR4 = 56'h526172211A0700;
    localparam logic [31:0]  MAGIC_XAR  = 32'h78617221;
    localparam logic [31:0]  MAGIC_DMG  = 32'h6B6F6C79;
    localparam logic [39:0]  MAGIC_PDF  = 40'h255044462D;
    localparam logic [31:0]  MAGIC_RPM  = 32'hEDABEEDB;
    localparam logic [23:0]  MAGIC_SWFC = 24'h435753;
    localparam logic [23:0]  MAGIC_SWFF = 24'h465753;
    localparam logic [39:0]  MAGIC_RTF  = 40'h7B5C727466;
    localparam logic [71:0]  MAGIC_MSI  = 72'h535A444488F0273341;
    localparam logic [31:0]  MAGIC_ZIP  = 32'h504B0304;
    // The "mimetypeapplication/epub+zip" run that follows the local header.
    localparam logic [223:0] MAGIC_EPUB_TAIL =
        224'h6D696D65_74797065_6170706C_69636174_696F6E2F_65707562_2B7A6970;
    localparam int EPUB_TAIL_AT  = 30;
    localparam int EPUB_TAIL_LEN = 28;

    localparam logic [7:0] LF      = 8'h0A;
    localparam logic [9:0] POS_TOP = 10'd1023;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } t_beat;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] byte_value
    logic        s_tlast  = 1'b0;    // last_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;            // [3:0] file_type, [35:4] version_major,
                                     // [43:36] version_minor, [47:44] zero

    // Byte words waiting to be sent, and classifications waiting to come out.
    t_beat   pending[$];
    t_result file_class_q[$];

    int words_total;
    int words_sent;
    int err_count;
    int cycle_count;
    int results_seen;

    // Scratch file under construction.
    logic [7:0] fbuf [0:BUF_LEN-1];
    int         flen;
    int         stim_bytes;
    int         rand_files;

    // Predictor copy of the per-file tracking state.
    logic [9:0]            trk_pos;
    logic [MG_COUNT-1:0]   trk_live;
    logic                  trk_nl;
    logic [7:0]            trk_7z_major;
    logic [7:0]            trk_7z_minor;
    logic [15:0]           trk_xar_size;
    logic [15:0]           trk_xar_ver;
    logic [31:0]           trk_dmg_ver;
    logic [31:0]           trk_dmg_size;

    // Idle bookkeeping for both sides.
    int send_gap;
    int send_burst;
    int stall_left;
    int stall_burst;

    magic_signature_file_classifier_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Number of leading bytes each signature compares; for the EPUB flag this is
    // only the zip local header signature, the tail run is handled on its own.
    function automatic int magic_len(input int id);
        case (id)
            MG_7Z:   return 6;
            MG_RAR5: return 8;
            MG_RAR4: return 7;
            MG_XAR:  return 4;
            MG_DMG:  return 4;
            MG_PDF:  return 5;
            MG_RPM:  return 4;
            MG_SWFC: return 3;
            MG_SWFF: return 3;
            MG_RTF:  return 5;
            MG_MSI:  return 9;
            MG_EPUB: return 4;
            default: return 0;
        endcase
    endfunction

    function automatic logic [7:0] magic_at(input int id, input int idx);
        int sh;
        sh = 8 * (magic_len(id) - 1 - idx);
        case (id)
            MG_7Z:   return MAGIC_7Z[sh +: 8];
            MG_RAR5: return MAGIC_RAR5[sh +: 8];
            MG_RAR4: return MAGIC_RAR4[sh +: 8];
            MG_XAR:  return MAGIC_XAR[sh +: 8];
            MG_DMG:  return MAGIC_DMG[sh +: 8];
            MG_PDF:  return MAGIC_PDF[sh +: 8];
            MG_RPM:  return MAGIC_RPM[sh +: 8];
            MG_SWFC: return MAGIC_SWFC[sh +: 8];
            MG_SWFF: return MAGIC_SWFF[sh +: 8];
            MG_RTF:  return MAGIC_RTF[sh +: 8];
            MG_MSI:  return MAGIC_MSI[sh +: 8];
            MG_EPUB: return MAGIC_ZIP[sh +: 8];
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] epub_tail_at(input int idx);
        return MAGIC_EPUB_TAIL[8 * (EPUB_TAIL_LEN - 1 - idx) +: 8];
    endfunction

    // Shortest file in which each signature can be reported.
    function automatic int min_file_len(input int id);
        case (id)
            MG_7Z, MG_RAR5, MG_PDF: return 8;
            MG_RAR4:                return 7;
            MG_XAR:                 return 28;
            MG_DMG:                 return 512;
            MG_RPM:                 return 4;
            MG_SWFC, MG_SWFF:       return 3;
            MG_RTF:                 return 5;
            MG_MSI:                 return 9;
            MG_EPUB:                return 58;
            default:                return 1;
        endcase
    endfunction

    // Mostly short idles, some medium, a few long ones.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic track_clear();
        trk_pos      = '0;
        trk_live     = '1;
        trk_nl       = 1'b0;
        trk_7z_major = '0;
        trk_7z_minor = '0;
        trk_xar_size = '0;
        trk_xar_ver  = '0;
        trk_dmg_ver  = '0;
        trk_dmg_size = '0;
    endtask

    // Advances the tracking state by one accepted byte. On the final byte of a
    // file it queues the expected classification and starts a fresh file.
    task automatic track_byte(input logic [7:0] v, input logic fin);
        int      p;
        int      flen_seen;
        t_result cls;
        p = trk_pos;
        for (int k = 0; k < MG_COUNT; k++) begin
            if (p < magic_len(k) && magic_at(k, p) != v) trk_live[k] = 1'b0;
        end
        if (p >= EPUB_TAIL_AT && p < EPUB_TAIL_AT + EPUB_TAIL_LEN &&
            epub_tail_at(p - EPUB_TAIL_AT) != v) begin
            trk_live[MG_EPUB] = 1'b0;
        end
        if (v == LF) trk_nl = 1'b1;
        if (p == 6) trk_7z_major = v;
        if (p == 7) trk_7z_minor = v;
        if (p == 4 || p == 5) trk_xar_size = {trk_xar_size[7:0], v};
        if (p == 6 || p == 7) trk_xar_ver = {trk_xar_ver[7:0], v};
        if (p >= 4 && p < 8) trk_dmg_ver = {trk_dmg_ver[23:0], v};
        if (p >= 8 && p < 12) trk_dmg_size = {trk_dmg_size[23:0], v};
        if (trk_pos != POS_TOP) trk_pos = trk_pos + 10'd1;
        if (fin) begin
            // The count saturates, so p + 1 still clears every length bound.
            flen_seen = p + 1;
            cls = '0;
            cls.file_type = FT_NONE;
            if (trk_live[MG_7Z] && flen_seen >= 8) begin
                cls.file_type     = FT_7Z;
                cls.version_major = {24'd0, trk_7z_major};
                cls.version_minor = trk_7z_minor;
            end else if (trk_live[MG_RAR5] && flen_seen >= 8) begin
                cls.file_type     = FT_RAR;
                cls.version_major = 32'd5;
            end else if (trk_live[MG_RAR4] && flen_seen >= 7) begin
                cls.file_type     = FT_RAR;
                cls.version_major = 32'd4;
            end else if (trk_live[MG_XAR] && flen_seen >= 28 && trk_xar_size >= 16'd28) begin
                cls.file_type     = FT_XAR;
                cls.version_major = {16'd0, trk_xar_ver};
            end else if (trk_live[MG_DMG] && flen_seen >= 512 &&
                         trk_dmg_size == 32'd512) begin
                cls.file_type     = FT_DMG;
                cls.version_major = trk_dmg_ver;
            end else if (trk_live[MG_PDF] && flen_seen >= 8 && trk_nl) begin
                cls.file_type = FT_PDF;
            end else if (trk_live[MG_RPM] && flen_seen >= 4) begin
                cls.file_type = FT_RPM;
            end else if ((trk_live[MG_SWFC] || trk_live[MG_SWFF]) && flen_seen >= 3) begin
                cls.file_type = FT_SWF;
            end else if (trk_live[MG_RTF] && flen_seen >= 5) begin
                cls.file_type = FT_RTF;
            end else if (trk_live[MG_MSI] && flen_seen >= 9) begin
                cls.file_type = FT_MSI;
            end else if (trk_live[MG_EPUB] && flen_seen >= 58) begin
                cls.file_type = FT_EPUB;
            end
            file_class_q = {file_class_q, cls};
            track_clear();
        end
    endtask

    // File building helpers: random body, signature overlay, big-endian fields.
    task automatic start_file(input int n);
        flen = n;
        for (int i = 0; i < n; i++) fbuf[i] = 8'($urandom_range(0, 255));
    endtask

    task automatic place_magic(input int id);
        for (int i = 0; i < magic_len(id) && i < flen; i++) fbuf[i] = magic_at(id, i);
        if (id == MG_EPUB) begin
            for (int i = 0; i < EPUB_TAIL_LEN && EPUB_TAIL_AT + i < flen; i++)
                fbuf[EPUB_TAIL_AT + i] = epub_tail_at(i);
        end
    endtask

    task automatic put_be(input int off, input logic [31:0] val, input int nb);
        for (int i = 0; i < nb; i++) begin
            if (off + i < flen) fbuf[off + i] = val[8 * (nb - 1 - i) +: 8];
        end
    endtask

    task automatic drop_newlines();
        for (int i = 0; i < flen; i++) begin
            if (fbuf[i] == LF) fbuf[i] = 8'h0B;
        end
    endtask

    task automatic emit_file();
        t_beat w;
        for (int i = 0; i < flen; i++) begin
            w.data = fbuf[i];
            w.fin  = (i == flen - 1);
            pending = {pending, w};
        end
        stim_bytes += flen;
    endtask

    // One directed file: signature over a random body of n bytes.
    task automatic plain_file(input int id, input int n);
        start_file(n);
        place_magic(id);
        emit_file();
    endtask

    task automatic random_file();
        int id;
        int n;
        int need;
        int hit;
        id = $urandom_range(0, MG_NOISE);
        // Disk images are at least 510 bytes each, so keep them rare.
        if (id == MG_DMG && $urandom_range(0, 7) != 0) id = MG_NOISE;
        if (id == MG_NOISE) begin
            n = $urandom_range(1, 24);
        end else begin
            need = min_file_len(id);
            n = need + $urandom_range(0, 4) - 2;
            if ($urandom_range(0, 7) == 0) n = need + $urandom_range(5, 60);
            if (n < 1) n = 1;
        end
        start_file(n);
        if (id != MG_NOISE) place_magic(id);
        case (id)
            MG_XAR: begin
                case ($urandom_range(0, 3))
                    0: put_be(4, 32'd27, 2);
                    1: put_be(4, 32'd28, 2);
                    2: put_be(4, 32'd29, 2);
                    default: put_be(4, 32'($urandom_range(0, 65535)), 2);
                endcase
            end
            MG_DMG: begin
                if ($urandom_range(0, 3) != 0) put_be(8, 32'd512, 4);
                else put_be(8, 32'd511 + 32'($urandom_range(0, 2)), 4);
            end
            MG_PDF: begin
                drop_newlines();
                if ($urandom_range(0, 1) == 1 && flen > 5)
                    fbuf[$urandom_range(5, flen - 1)] = LF;
            end
            default: ;
        endcase
        // Now and then damage one header byte so near-miss signatures show up.
        if ($urandom_range(0, 9) == 0) begin
            hit = (flen < 12) ? flen : 12;
            fbuf[$urandom_range(0, hit - 1)] = 8'($urandom_range(0, 255));
        end
        emit_file();
        rand_files++;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < PRINT_CAP)
            $display("%0t: result %0d %s mismatch: got 0x%0h, expected 0x%0h",
                     $realtime, results_seen, what, got, want);
        err_count++;
    endtask

    // Stimulus, reset and end of run.
    initial begin
        track_clear();
        err_count   = 0;
        words_sent  = 0;
        stim_bytes  = 0;
        rand_files  = 0;

        // Each known type with its smallest full header, plus the ways to miss it.
        start_file(8); place_magic(MG_7Z); fbuf[6] = 8'hFF; fbuf[7] = 8'h00; emit_file();
        start_file(8); place_magic(MG_7Z); fbuf[6] = 8'h00; fbuf[7] = 8'hFF; emit_file();
        plain_file(MG_7Z, 7);
        plain_file(MG_RAR5, 8);
        plain_file(MG_RAR4, 7);
        plain_file(MG_RAR4, 6);
        // RAR5 prefix cut one byte short is neither RAR5 nor RAR4.
        plain_file(MG_RAR5, 7);
        start_file(28); place_magic(MG_XAR); put_be(4, 32'd28, 2);
        put_be(6, 32'hFFFF, 2); emit_file();
        start_file(30); place_magic(MG_XAR); put_be(4, 32'd27, 2); emit_file();
        start_file(27); place_magic(MG_XAR); put_be(4, 32'hFFFF, 2); emit_file();
        start_file(512); place_magic(MG_DMG); put_be(8, 32'd513, 4); emit_file();
        start_file(8); place_magic(MG_PDF); drop_newlines(); fbuf[7] = LF; emit_file();
        start_file(8); place_magic(MG_PDF); drop_newlines(); emit_file();
        start_file(7); place_magic(MG_PDF); drop_newlines(); fbuf[6] = LF; emit_file();
        plain_file(MG_RPM, 4);
        plain_file(MG_SWFC, 3);
        plain_file(MG_SWFF, 3);
        plain_file(MG_RTF, 5);
        plain_file(MG_MSI, 9);
        plain_file(MG_MSI, 8);
        plain_file(MG_EPUB, 58);
        plain_file(MG_EPUB, 57);
        start_file(58); place_magic(MG_EPUB); fbuf[57] = 8'h00; emit_file();
        // Single-byte files at both byte extremes.
        start_file(1); fbuf[0] = 8'h00; emit_file();
        start_file(1); fbuf[0] = 8'hFF; emit_file();
        // A disk image just past the saturation point of the byte counter.
        start_file(1025); place_magic(MG_DMG); put_be(4, 32'hFFFFFFFF, 4);
        put_be(8, 32'd512, 4); emit_file();

        // Random files, mostly well-formed signatures around their length bounds.
        while (stim_bytes < ITEM_TARGET || rand_files < RAND_FILES) random_file();
        words_total = pending.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_sent != words_total) @(posedge i_clk);
        while (file_class_q.size() != 0) @(posedge i_clk);
        // Give any stray result word time to get past a stalled ready.
        repeat (DRAIN_LEN) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Byte driver: presents words from the pending queue with random idles in between.
    always @(posedge i_clk) begin
        t_beat w;
        if (!i_rst_n) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= 8'h00;
            s_tlast    <= 1'b0;
            send_gap    = 0;
            send_burst  = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_byte(s_tdata, s_tlast);
                words_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending.size() != 0) begin
                    w = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= w.data;
                    s_tlast  <= w.fin;
                    // Occasional bursts with no idles at all between words.
                    if (send_burst > 0) begin
                        send_burst--;
                        send_gap = 0;
                    end else begin
                        send_gap = idle_len();
                        if ($urandom_range(0, 49) == 0) send_burst = $urandom_range(20, 80);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each accepted result word and toggles ready at random.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            m_tready   <= 1'b0;
            stall_left  = 0;
            stall_burst = 0;
            results_seen = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (file_class_q.size() == 0) begin
                    report_mismatch("unexpected word, file_type", 32'(m_tdata[3:0]), '0);
                end else begin
                    want = file_class_q.pop_front();
                    if (m_tdata[3:0] != want.file_type)
                        report_mismatch("file_type", 32'(m_tdata[3:0]), 32'(want.file_type));
                    if (m_tdata[35:4] != want.version_major)
                        report_mismatch("version_major", m_tdata[35:4], want.version_major);
                    if (m_tdata[43:36] != want.version_minor)
                        report_mismatch("version_minor", 32'(m_tdata[43:36]),
                                        32'(want.version_minor));
                    if (m_tdata[47:44] != 4'd0)
                        report_mismatch("pad bits", 32'(m_tdata[47:44]), '0);
                end
                results_seen++;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (stall_burst > 0) begin
                    stall_burst--;
                end else begin
                    stall_left = idle_len();
                    if ($urandom_range(0, 49) == 0) stall_burst = $urandom_range(20, 80);
                end
            end
        end
    end

    // Hang guard.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial cycle_count = 0;

endmodule
